@@ rtl/bcpe_pkg.sv @@
// ----------------------------------------------------------------------------
// bcpe_pkg
// Shared widths, codes and the control word of the Bezier point evaluator.
// ----------------------------------------------------------------------------
package bcpe_pkg;

  localparam int MAX_POINTS = 8;
  localparam int IDX_W      = 3;    // point_index
  localparam int COORD_W    = 16;   // integer control point coordinate
  localparam int T_W        = 17;   // time_fraction, Q0.16 with 1.0 reachable
  localparam int T_FRAC     = 16;
  localparam int FRAC_W     = 24;   // working fraction bits
  localparam int W_W        = COORD_W + FRAC_W;            // working value
  localparam int POS_W      = 24;   // Q16.8 result
  localparam int CNT_W      = 4;    // point_count register
  localparam int LVL_W      = 3;    // levels, up to MAX_POINTS-1

  // b - a is split in a low and a high part for the multiply
  localparam int LO_W       = 21;
  localparam int HI_W       = W_W + 1 - LO_W;
  localparam int PLO_W      = LO_W + T_W;
  localparam int PHI_W      = HI_W + T_W + 1;
  localparam int SUM_W      = PHI_W + LO_W;

  localparam logic [T_W-1:0]    T_ONE     = T_W'(1) << T_FRAC;
  localparam logic [T_FRAC-1:0] T_HALF    = T_FRAC'(1) << (T_FRAC - 1);
  localparam logic [CNT_W-1:0]  CNT_RESET = CNT_W'(4);
  localparam logic [CNT_W-1:0]  CNT_MIN   = CNT_W'(2);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_POINTS);

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;

  // step strobes broadcast to every cell
  typedef struct packed {
    logic load;   // working value <= control point
    logic diff;   // register neighbor - own
    logic mul;    // register partial products with t
    logic acc;    // working value <= own + rounded product
  } ctrl_t;

endpackage

@@ rtl/bcpe_cell.sv @@
// ----------------------------------------------------------------------------
// bcpe_cell
// One de Casteljau cell: holds one control point and one working value per
// axis, and interpolates toward its right-hand neighbor once per level.
// ----------------------------------------------------------------------------
module bcpe_cell (
  input  logic                                clk,
  input  bcpe_pkg::ctrl_t                     ctrl,
  input  logic                                wr_en,
  input  logic signed [bcpe_pkg::COORD_W-1:0] wr_x,
  input  logic signed [bcpe_pkg::COORD_W-1:0] wr_y,
  input  logic        [bcpe_pkg::T_W-1:0]     t,
  input  logic        [bcpe_pkg::W_W-1:0]     nb_x,
  input  logic        [bcpe_pkg::W_W-1:0]     nb_y,
  output logic        [bcpe_pkg::W_W-1:0]     w_x,
  output logic        [bcpe_pkg::W_W-1:0]     w_y
);
  import bcpe_pkg::*;

  // lane 0 is x, lane 1 is y
  logic        [COORD_W-1:0] pt    [2];
  logic        [W_W-1:0]     w     [2];
  logic        [W_W-1:0]     nb    [2];
  logic        [W_W:0]       diff  [2];
  logic        [PLO_W-1:0]   p_lo  [2];
  logic signed [PHI_W-1:0]   p_hi  [2];
  logic        [SUM_W-1:0]   sum   [2];

  assign nb[0] = nb_x;
  assign nb[1] = nb_y;
  assign w_x   = w[0];
  assign w_y   = w[1];

  // a*2^16 + half + (b-a)*t in one three-operand add; floor shift by 16 after
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sum[l] = {{(SUM_W - W_W - T_FRAC){w[l][W_W-1]}}, w[l], T_HALF}
             + {p_hi[l], {LO_W{1'b0}}}
             + {{(SUM_W - PLO_W){1'b0}}, p_lo[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pt[0] <= wr_x;
      pt[1] <= wr_y;
    end
    for (int l = 0; l < 2; l++) begin
      if (ctrl.load) begin
        w[l] <= {pt[l], {FRAC_W{1'b0}}};
      end else if (ctrl.acc) begin
        w[l] <= sum[l][W_W+T_FRAC-1:T_FRAC];
      end
      if (ctrl.diff) begin
        diff[l] <= {nb[l][W_W-1], nb[l]} - {w[l][W_W-1], w[l]};
      end
      if (ctrl.mul) begin
        p_lo[l] <= PLO_W'(diff[l][LO_W-1:0]) * PLO_W'(t);
        p_hi[l] <= PHI_W'($signed(diff[l][W_W:LO_W])) * PHI_W'($signed({1'b0, t}));
      end
    end
  end

endmodule

@@ rtl/bcpe_seq.sv @@
// ----------------------------------------------------------------------------
// bcpe_seq
// Level sequencer: steps the cell row through diff, multiply and accumulate
// once per level, then hands the result to the output register.
// ----------------------------------------------------------------------------
module bcpe_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         eval_start,
  input  logic [bcpe_pkg::CNT_W-1:0]   point_count,
  input  logic                         out_free,
  output bcpe_pkg::ctrl_t              ctrl,
  output logic                         out_load,
  output logic                         idle
);
  import bcpe_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIFF = 5'b00010,
    S_MUL  = 5'b00100,
    S_ACC  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t            state, state_next;
  logic [LVL_W-1:0]  level, level_next;
  logic [CNT_W-1:0]  n_clamp;

  always_comb begin
    if (point_count < CNT_MIN) begin
      n_clamp = CNT_MIN;
    end else if (point_count > CNT_MAX) begin
      n_clamp = CNT_MAX;
    end else begin
      n_clamp = point_count;
    end
  end

  always_comb begin
    state_next = state;
    level_next = level;
    unique case (state)
      S_IDLE: begin
        if (eval_start) begin
          state_next = S_DIFF;
          level_next = LVL_W'(n_clamp - CNT_W'(1));
        end
      end
      S_DIFF: state_next = S_MUL;
      S_MUL:  state_next = S_ACC;
      S_ACC: begin
        if (level == LVL_W'(1)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_DIFF;
          level_next = level - LVL_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      level <= '0;
    end else begin
      state <= state_next;
      level <= level_next;
    end
  end

  assign idle      = (state == S_IDLE);
  assign ctrl.load = eval_start && (state == S_IDLE);
  assign ctrl.diff = (state == S_DIFF);
  assign ctrl.mul  = (state == S_MUL);
  assign ctrl.acc  = (state == S_ACC);
  assign out_load  = (state == S_DONE) && out_free;

endmodule

@@ rtl/bezier_curve_point_eval_core.sv @@
// ----------------------------------------------------------------------------
// bezier_curve_point_eval_core
// 2-D Bezier curve evaluator, de Casteljau over a row of interpolating cells.
// ----------------------------------------------------------------------------
// Use:
//   s_* stream in: s_tuser is the mode. Mode write stores (x, y) at
//   point_index in the cell of that index and yields no output word. Mode
//   evaluate takes t (Q0.16, saturated to 1.0) and yields one m_* word with
//   the curve point in signed Q16.8, rounded to nearest, ties upward.
//   cfg_wr_en / cfg_wr_data set point_count (2..8 used, clamped outside);
//   write it only while the block is idle.
// Timing:
//   A write word is taken whenever the block is idle.
//   An evaluation runs n-1 levels (n = clamped point_count), each stepping
//   the cell row through difference, split multiply, rounded accumulate.
//   The result then loads into the output register, which drives m_tvalid;
//   the next word is taken once the sequencer is back in idle, so a new
//   evaluation is not taken while one is still running.
// Reset:
//   rst clears the sequencer, the output valid and point_count (to 4).
//   Stored control points are undefined until written.
// Stall:
//   The result waits in the output register; write words are still taken
//   meanwhile. A finished evaluation holds in its last step until the output
//   register is free.
// ----------------------------------------------------------------------------
module bezier_curve_point_eval_core (
  input  logic        clk,
  input  logic        rst,
  // configuration: point_count
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // point_index[2:0], point_x[18:3], point_y[34:19],
                                 // time_fraction[51:35], zero pad[55:52]
  input  logic        s_tuser,   // mode
  // output words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // pos_x[23:0], pos_y[47:24]
);
  import bcpe_pkg::*;

  logic                      in_accept;
  logic [IDX_W-1:0]          point_index;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic [T_W-1:0]            time_fraction;
  logic                      mode;

  logic [CNT_W-1:0]          point_count;
  logic [T_W-1:0]            t_reg;
  logic [POS_W-1:0]          pos_x, pos_y;
  logic [W_W-1:0]            rnd_x, rnd_y;

  ctrl_t                     ctrl;
  logic                      out_load;
  logic                      idle;
  logic                      out_free;
  logic                      eval_start;

  logic [W_W-1:0]            cw_x [MAX_POINTS];
  logic [W_W-1:0]            cw_y [MAX_POINTS];

  // unpack input word
  assign point_index   = s_tdata[IDX_W-1:0];
  assign point_x       = s_tdata[IDX_W+COORD_W-1:IDX_W];
  assign point_y       = s_tdata[IDX_W+2*COORD_W-1:IDX_W+COORD_W];
  assign time_fraction = s_tdata[IDX_W+2*COORD_W+T_W-1:IDX_W+2*COORD_W];
  assign mode          = s_tuser;

  assign s_tready   = idle;
  assign in_accept  = s_tvalid && s_tready;
  assign eval_start = in_accept && (mode == MODE_EVAL);
  assign out_free   = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= CNT_RESET;
    end else if (cfg_wr_en) begin
      point_count <= cfg_wr_data;
    end
  end

  // t is latched at acceptance, saturated to 1.0
  always_ff @(posedge clk) begin
    if (eval_start) begin
      t_reg <= (time_fraction > T_ONE) ? T_ONE : time_fraction;
    end
  end

  bcpe_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .eval_start  (eval_start),
    .point_count (point_count),
    .out_free    (out_free),
    .ctrl        (ctrl),
    .out_load    (out_load),
    .idle        (idle)
  );

  // cell row: cell i owns control point i and reads cell i+1 each level;
  // the last cell sees zeros, its output never reaches cell 0
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    logic [W_W-1:0] nb_x, nb_y;
    if (i == MAX_POINTS - 1) begin : g_end
      assign nb_x = '0;
      assign nb_y = '0;
    end else begin : g_mid
      assign nb_x = cw_x[i+1];
      assign nb_y = cw_y[i+1];
    end

    bcpe_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .wr_en (in_accept && (mode == MODE_WRITE) && (point_index == IDX_W'(i))),
      .wr_x  (point_x),
      .wr_y  (point_y),
      .t     (t_reg),
      .nb_x  (nb_x),
      .nb_y  (nb_y),
      .w_x   (cw_x[i]),
      .w_y   (cw_y[i])
    );
  end

  // Q.24 to Q.8, nearest with ties upward: add half, floor shift
  assign rnd_x = cw_x[0] + W_W'(T_HALF);
  assign rnd_y = cw_y[0] + W_W'(T_HALF);

  always_ff @(posedge clk) begin
    if (out_load) begin
      pos_x <= rnd_x[POS_W+T_FRAC-1:T_FRAC];
      pos_y <= rnd_y[POS_W+T_FRAC-1:T_FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {pos_y, pos_x};

endmodule
